>>> sv/assert_macros.svh
// Assertion macros shared by the proxy client RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, switched off while rst_n is low.
`define APC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, switched off while rst_n is low.
`define APC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/apc_pkg.sv
// Types and constants shared by the proxy client state machine modules.
package apc_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PRIMARY_MAC    = 2'd0,
        CFG_PREFERRED_ID   = 2'd1,
        CFG_NOP_INTERVAL   = 2'd2
    } cfg_idx_t;

    localparam logic [15:0] NOP_INTERVAL_RESET = 16'd10000;

    // Positions of the sticky event flags.
    localparam int F_TCP     = 0;
    localparam int F_FIN     = 1;
    localparam int F_CLOSED  = 2;
    localparam int F_LINK    = 3;
    localparam int F_SRV_IN  = 4;
    localparam int F_CLI_OUT = 5;
    localparam int F_ID      = 6;
    localparam int FLAG_W    = 7;

    // Action codes reported with each result.
    typedef enum logic [3:0] {
        ACT_NONE    = 4'd0,
        ACT_CONNECT = 4'd1,
        ACT_HTTP    = 4'd2,
        ACT_ID_REQ  = 4'd3,
        ACT_CLOSE   = 4'd4,
        ACT_LINK    = 4'd5,
        ACT_PROCESS = 4'd6,
        ACT_SEND    = 4'd7,
        ACT_NEW_ID  = 4'd8,
        ACT_NOP     = 4'd9
    } action_t;

    typedef struct packed {
        logic [63:0] pref_eid;
        logic [15:0] nop_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic        opcode;
        logic [47:0] now_ms;
        logic        ev_tcp_connected;
        logic        ev_finish;
        logic        ev_incoming_closed;
        logic        ev_link_status;
        logic        ev_server_msg_in;
        logic        ev_client_msg_out;
        logic        ev_id_assigned;
        logic [63:0] new_entity_id;
        logic        http_response_ok;
    } item_t;

    typedef struct packed {
        logic [3:0]  state_code;
        action_t     action;
        logic [63:0] cur_eid;
        logic        client_msg_accepted;
    } res_t;

endpackage

>>> sv/avdecc_proxy_client_fsm_unit.sv
// Top level of the proxy client control state machine.
//
//  Channel  | Direction | Handshake             | Contents
//  ---------+-----------+-----------------------+------------------------------------
//  s_axis   | in        | tvalid / tready       | one request: start command or step
//  m_axis   | out       | tvalid / tready       | one result per request
//  cfg      | in        | cfg_valid / cfg_ready | register writes, index and data
//
// Each request passes through the input register and then the result
// register; a new request is accepted in every cycle while downstream takes
// each result. The single transition step between the two registers has
// its longest path in the 48-bit deadline add and compare.
// The input register is refilled in the same cycle that its request moves on.
// While a finished result waits downstream, one further request is held in the
// input register and the input then stalls until the result is taken.
// Reset (rst_n low, asynchronous) leaves the machine in the end state with all
// flags, the deadline and the entity IDs at zero, and the NOP interval at 10000.
// The configuration port is always ready; writes are expected only while idle.
`include "assert_macros.svh"
module avdecc_proxy_client_fsm_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [47:0] now_ms, [48] ev_tcp_connected, [49] ev_finish, [50] ev_incoming_closed,
    // [51] ev_link_status, [52] ev_server_msg_in, [53] ev_client_msg_out,
    // [54] ev_id_assigned, [118:55] new_entity_id, [119] http_response_ok
    input  logic [119:0] s_axis_tdata,
    // [0] opcode
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] state_code, [7:4] action, [71:8] current entity ID,
    // [72] client_msg_accepted, [79:73] zero
    output logic [79:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    apc_pkg::cfg_t  cfg;
    apc_pkg::item_t in_item;
    apc_pkg::item_t in_item_reg;
    apc_pkg::item_t in_item_next;
    apc_pkg::res_t  res;
    apc_pkg::res_t  out_res_reg;
    apc_pkg::res_t  out_res_next;
    logic           in_vld_reg;
    logic           in_vld_next;
    logic           out_vld_reg;
    logic           out_vld_next;
    logic           adv;
    logic           s_take;

    assign cfg_ready = 1'b1;

    apc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Unpack the incoming request.
    assign in_item.opcode             = s_axis_tuser[0];
    assign in_item.now_ms             = s_axis_tdata[47:0];
    assign in_item.ev_tcp_connected   = s_axis_tdata[48];
    assign in_item.ev_finish          = s_axis_tdata[49];
    assign in_item.ev_incoming_closed = s_axis_tdata[50];
    assign in_item.ev_link_status     = s_axis_tdata[51];
    assign in_item.ev_server_msg_in   = s_axis_tdata[52];
    assign in_item.ev_client_msg_out  = s_axis_tdata[53];
    assign in_item.ev_id_assigned     = s_axis_tdata[54];
    assign in_item.new_entity_id      = s_axis_tdata[118:55];
    assign in_item.http_response_ok   = s_axis_tdata[119];

    // The held request moves into the result register, and updates the
    // machine's state, whenever that register is empty or being drained.
    assign adv           = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || adv;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    apc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (adv),
        .item  (in_item_reg),
        .res   (res)
    );

    always_comb
    begin
        in_vld_next  = in_vld_reg;
        in_item_next = in_item_reg;
        out_vld_next = out_vld_reg;
        out_res_next = out_res_reg;
        if (s_take)
        begin
            in_vld_next  = 1'b1;
            in_item_next = in_item;
        end
        else if (adv)
        begin
            in_vld_next = 1'b0;
        end
        if (adv)
        begin
            out_vld_next = 1'b1;
            out_res_next = res;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Control bits are reset; the payload registers are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, out_res_reg.client_msg_accepted, out_res_reg.cur_eid,
                            out_res_reg.action, out_res_reg.state_code};

    `APC_ASSERT_NEXT(a_held_request_kept, in_vld_reg && !adv, in_vld_reg && $stable(in_item_reg.now_ms), "held request lost while stalled")
    `APC_ASSERT_NEXT(a_result_loaded, adv, out_vld_reg, "result register not loaded after advance")

endmodule

>>> sv/apc_cfg_regs.sv
// Configuration registers of the proxy client state machine.
module apc_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [63:0]        wr_data,
    output apc_pkg::cfg_t      cfg
);

    logic [63:0] preferred_id_reg;
    logic [63:0] preferred_id_next;
    logic [15:0] nop_interval_reg;
    logic [15:0] nop_interval_next;

    always_comb
    begin
        preferred_id_next = preferred_id_reg;
        nop_interval_next = nop_interval_reg;
        if (wr_en)
        begin
            case (apc_pkg::cfg_idx_t'(wr_index))
                apc_pkg::CFG_PRIMARY_MAC:
                begin
                    // The MAC only goes into the ID request frame, which is
                    // built outside this block, so nothing is kept here.
                end
                apc_pkg::CFG_PREFERRED_ID: preferred_id_next = wr_data;
                apc_pkg::CFG_NOP_INTERVAL: nop_interval_next = wr_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preferred_id_reg <= '0;
            nop_interval_reg <= apc_pkg::NOP_INTERVAL_RESET;
        end
        else
        begin
            preferred_id_reg <= preferred_id_next;
            nop_interval_reg <= nop_interval_next;
        end
    end

    assign cfg.pref_eid        = preferred_id_reg;
    assign cfg.nop_interval_ms = nop_interval_reg;

endmodule

>>> sv/apc_core.sv
// Transition logic and state registers of the proxy client state machine.
`include "assert_macros.svh"
module apc_core (
    input  logic           clk,
    input  logic           rst_n,
    input  apc_pkg::cfg_t  cfg,
    input  logic           fire,
    input  apc_pkg::item_t item,
    output apc_pkg::res_t  res
);

    typedef enum logic [3:0] {
        S_BEGIN      = 4'd0,
        S_INIT       = 4'd1,
        S_WAIT_CONN  = 4'd2,
        S_ACCEPT     = 4'd3,
        S_START_XFER = 4'd4,
        S_WAITING    = 4'd5,
        S_CLOSED     = 4'd6,
        S_LINK       = 4'd7,
        S_RECV       = 4'd8,
        S_SEND       = 4'd9,
        S_ID         = 4'd10,
        S_NOP        = 4'd11,
        S_FINISH     = 4'd12,
        S_END        = 4'd13
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [apc_pkg::FLAG_W-1:0]  flags_reg;
    logic [apc_pkg::FLAG_W-1:0]  flags_next;
    logic [apc_pkg::FLAG_W-1:0]  events;
    logic [47:0]                 deadline_reg;
    logic [47:0]                 deadline_next;
    logic [47:0]                 rearm_time;
    logic [63:0]                 cur_id_reg;
    logic [63:0]                 cur_id_next;
    logic [63:0]                 pend_id_reg;
    logic [63:0]                 pend_id_next;
    apc_pkg::action_t            action;
    logic                        accepted;
    logic                        chk_accept;
    logic                        chk_keep_id;

    assign events = {item.ev_id_assigned, item.ev_client_msg_out, item.ev_server_msg_in,
                     item.ev_link_status, item.ev_incoming_closed, item.ev_finish,
                     item.ev_tcp_connected};

    // The deadline wraps modulo 2^48 and is compared as a plain value.
    assign rearm_time = item.now_ms + {32'd0, cfg.nop_interval_ms};

    always_comb
    begin
        state_next    = state_reg;
        flags_next    = flags_reg;
        deadline_next = deadline_reg;
        cur_id_next   = cur_id_reg;
        pend_id_next  = pend_id_reg;
        action        = apc_pkg::ACT_NONE;
        accepted      = 1'b0;

        if (item.opcode)
        begin
            cur_id_next = cfg.pref_eid;
            state_next  = S_BEGIN;
        end
        else
        begin
            // An outgoing message is dropped while another one is pending.
            accepted   = item.ev_client_msg_out & ~flags_reg[apc_pkg::F_CLI_OUT];
            flags_next = flags_reg | events;
            if (item.ev_id_assigned)
            begin
                pend_id_next = item.new_entity_id;
            end

            case (state_reg)
                S_BEGIN:
                begin
                    state_next = S_INIT;
                    flags_next = '0;
                    action     = apc_pkg::ACT_CONNECT;
                end
                S_INIT:
                begin
                    state_next = S_WAIT_CONN;
                end
                S_WAIT_CONN:
                begin
                    if (flags_next[apc_pkg::F_TCP])
                    begin
                        state_next = S_ACCEPT;
                        action     = apc_pkg::ACT_HTTP;
                    end
                    else if (flags_next[apc_pkg::F_FIN])
                    begin
                        state_next = S_FINISH;
                    end
                end
                S_ACCEPT:
                begin
                    if (item.http_response_ok)
                    begin
                        state_next    = S_START_XFER;
                        action        = apc_pkg::ACT_ID_REQ;
                        deadline_next = rearm_time;
                    end
                    else
                    begin
                        state_next = S_CLOSED;
                        action     = apc_pkg::ACT_CLOSE;
                    end
                end
                S_START_XFER, S_LINK, S_RECV, S_SEND, S_ID, S_NOP:
                begin
                    state_next = S_WAITING;
                end
                S_WAITING:
                begin
                    // Pending events are served in fixed priority order.
                    if (flags_next[apc_pkg::F_CLOSED] || flags_next[apc_pkg::F_FIN])
                    begin
                        state_next = S_CLOSED;
                        action     = apc_pkg::ACT_CLOSE;
                    end
                    else if (flags_next[apc_pkg::F_LINK])
                    begin
                        state_next                   = S_LINK;
                        action                       = apc_pkg::ACT_LINK;
                        flags_next[apc_pkg::F_LINK]  = 1'b0;
                    end
                    else if (flags_next[apc_pkg::F_SRV_IN])
                    begin
                        state_next                    = S_RECV;
                        action                        = apc_pkg::ACT_PROCESS;
                        flags_next[apc_pkg::F_SRV_IN] = 1'b0;
                    end
                    else if (flags_next[apc_pkg::F_CLI_OUT])
                    begin
                        state_next                     = S_SEND;
                        action                         = apc_pkg::ACT_SEND;
                        flags_next[apc_pkg::F_CLI_OUT] = 1'b0;
                        deadline_next                  = rearm_time;
                    end
                    else if (flags_next[apc_pkg::F_ID])
                    begin
                        state_next                = S_ID;
                        action                    = apc_pkg::ACT_NEW_ID;
                        cur_id_next               = pend_id_next;
                        flags_next[apc_pkg::F_ID] = 1'b0;
                        deadline_next             = rearm_time;
                    end
                    else if (item.now_ms > deadline_reg)
                    begin
                        state_next    = S_NOP;
                        action        = apc_pkg::ACT_NOP;
                        deadline_next = rearm_time;
                    end
                end
                S_CLOSED:
                begin
                    state_next = S_FINISH;
                end
                S_FINISH:
                begin
                    state_next = S_END;
                end
                S_END:
                begin
                end
                default:
                begin
                    state_next = S_END;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_END;
            flags_reg    <= '0;
            deadline_reg <= '0;
            cur_id_reg   <= '0;
            pend_id_reg  <= '0;
        end
        else if (fire)
        begin
            state_reg    <= state_next;
            flags_reg    <= flags_next;
            deadline_reg <= deadline_next;
            cur_id_reg   <= cur_id_next;
            pend_id_reg  <= pend_id_next;
        end
    end

    assign res.state_code          = state_next;
    assign res.action              = action;
    assign res.cur_eid             = cur_id_next;
    assign res.client_msg_accepted = accepted;

    // Checks only look at a request that is actually being processed.
    assign chk_accept  = fire && accepted;
    assign chk_keep_id = fire && !item.opcode && (action != apc_pkg::ACT_NEW_ID);

    `APC_ASSERT_NEXT(a_start_to_begin, fire && item.opcode, state_reg == S_BEGIN, "start did not enter begin")
    `APC_ASSERT_IMPL(a_accept_needs_free, chk_accept, !flags_reg[apc_pkg::F_CLI_OUT], "double accept")
    `APC_ASSERT_IMPL(a_id_only_on_serve, chk_keep_id, res.cur_eid == cur_id_reg, "entity id changed")

endmodule
